FILE: rtl/core/tar_stream_router_macros.svh
// ----------------------------------------------------------------------------
// tar_stream_router_macros.svh
// Assertion helpers shared by the archive router RTL.
// ----------------------------------------------------------------------------
`ifndef TAR_STREAM_ROUTER_MACROS_SVH
`define TAR_STREAM_ROUTER_MACROS_SVH

// Same-cycle implication, quiet while rst is high.
`define TSR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while rst is high.
`define TSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Types, codes and header layout constants for the archive router.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int OFF_W  = 9;   // offset inside a 512-byte block
  localparam int SIZE_W = 36;  // parsed file size
  localparam int SIZE_DIGITS = 12;

  localparam logic [OFF_W-1:0] LAST_OFF = 9'd511;
  localparam logic [OFF_W-1:0] DIR_LEN  = 9'd5;
  localparam logic [OFF_W-1:0] FW_LEN   = 9'd16;
  localparam logic [OFF_W-1:0] SIZE_AT  = 9'd124;
  localparam logic [OFF_W-1:0] SIZE_END = SIZE_AT + OFF_W'(SIZE_DIGITS);
  localparam logic [OFF_W-1:0] TYPE_AT  = 9'd156;
  localparam logic [OFF_W-1:0] MAGIC_AT = 9'd257;
  localparam logic [OFF_W-1:0] MAGIC_END = 9'd262;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'

  localparam logic [7:0] MAGIC_TEXT [5] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};
  localparam logic [7:0] DIR_A [5] = '{8'h68, 8'h74, 8'h6D, 8'h6C, 8'h2F};
  localparam logic [7:0] DIR_B [5] = '{8'h66, 8'h70, 8'h67, 8'h61, 8'h2F};
  localparam logic [7:0] FW_PATH [16] = '{
    8'h62, 8'h75, 8'h69, 8'h6C, 8'h64, 8'h2F, 8'h74, 8'h72,
    8'h73, 8'h2D, 8'h69, 8'h6F, 8'h2E, 8'h62, 8'h69, 8'h6E
  };

  // name flag bits
  localparam int NF_DIR_A = 0;
  localparam int NF_DIR_B = 1;
  localparam int NF_FW    = 2;
  localparam int NF_NAME  = 3;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_END     = 2'd2,
    KIND_CORRUPT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_DIR  = 2'd1,
    DEST_FW   = 2'd2
  } dest_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  // Header fields gathered so far, from the parser to the sequencer.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [3:0]        name_flags;
    logic              magic_ok;
    logic              regular;
  } hdr_stat_t;

  typedef struct packed {
    kind_t             kind;
    dest_t             dest;
    logic [7:0]        payload;
    logic [SIZE_W-1:0] length;
    logic              last;
  } result_t;

endpackage

FILE: rtl/core/tsr_hdr.sv
// ----------------------------------------------------------------------------
// tsr_hdr
// Header field parser: name matches, octal size, type flag, magic.
// ----------------------------------------------------------------------------
module tsr_hdr (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     hdr_en,
  input  logic [tsr_pkg::OFF_W-1:0] off,
  input  logic [7:0]               data_byte,
  output tsr_pkg::hdr_stat_t       stat
);
  import tsr_pkg::*;

  logic [SIZE_W-1:0] size_acc, size_acc_next;
  logic              oct_ok, oct_ok_next;
  logic [3:0]        name_flags, name_flags_next;
  logic              magic_ok, magic_ok_next;
  logic              regular, regular_next;
  logic [OFF_W-1:0]  magic_idx;

  assign magic_idx = off - MAGIC_AT;

  always_comb begin
    size_acc_next   = size_acc;
    oct_ok_next     = oct_ok;
    name_flags_next = name_flags;
    magic_ok_next   = magic_ok;
    regular_next    = regular;
    if (hdr_en) begin
      if (off == '0) begin
        size_acc_next   = '0;
        oct_ok_next     = 1'b1;
        name_flags_next = 4'hF;
        magic_ok_next   = 1'b1;
        regular_next    = 1'b0;
        if (data_byte == 8'h00) name_flags_next[NF_NAME] = 1'b0;
      end
      if (off < DIR_LEN) begin
        if (data_byte != DIR_A[off[2:0]]) name_flags_next[NF_DIR_A] = 1'b0;
        if (data_byte != DIR_B[off[2:0]]) name_flags_next[NF_DIR_B] = 1'b0;
      end
      if (off < FW_LEN) begin
        if (data_byte != FW_PATH[off[3:0]]) name_flags_next[NF_FW] = 1'b0;
      end else if (off == FW_LEN) begin
        // path must be NUL terminated right after its last char
        if (data_byte != 8'h00) name_flags_next[NF_FW] = 1'b0;
      end
      if (off >= SIZE_AT && off < SIZE_END) begin
        if (oct_ok_next && data_byte >= CH_ZERO && data_byte <= CH_SEVEN) begin
          size_acc_next = {size_acc_next[SIZE_W-4:0], data_byte[2:0]};
        end else begin
          oct_ok_next = 1'b0;
        end
      end
      if (off == TYPE_AT) begin
        regular_next = (data_byte == CH_ZERO) || (data_byte == 8'h00);
      end
      if (off >= MAGIC_AT && off < MAGIC_END) begin
        if (data_byte != MAGIC_TEXT[magic_idx[2:0]]) magic_ok_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_acc   <= '0;
      oct_ok     <= 1'b1;
      name_flags <= 4'hF;
      magic_ok   <= 1'b1;
      regular    <= 1'b0;
    end else begin
      size_acc   <= size_acc_next;
      oct_ok     <= oct_ok_next;
      name_flags <= name_flags_next;
      magic_ok   <= magic_ok_next;
      regular    <= regular_next;
    end
  end

  assign stat.size       = size_acc;
  assign stat.name_flags = name_flags;
  assign stat.magic_ok   = magic_ok;
  assign stat.regular    = regular;

endmodule

FILE: rtl/core/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Block sequencer: phase, block offset, payload count and result forming.
// ----------------------------------------------------------------------------
module tsr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  tsr_pkg::hdr_stat_t        stat,
  output logic                      hdr_en,
  output logic [tsr_pkg::OFF_W-1:0] off,
  output logic                      res_valid,
  output tsr_pkg::result_t          res
);
  import tsr_pkg::*;

  phase_t            phase, phase_next;
  logic [OFF_W-1:0]  block_offset, block_offset_next;
  logic [SIZE_W-1:0] remaining, remaining_next, remaining_dec;
  dest_t             cur_dest, cur_dest_next;
  dest_t             hdr_dest;
  logic [OFF_W-1:0]  off_inc;

  assign off     = block_offset;
  assign off_inc = block_offset + OFF_W'(1);
  assign hdr_en  = step && (phase == PH_HEADER);
  assign remaining_dec = (remaining != '0) ? remaining - SIZE_W'(1) : remaining;

  always_comb begin
    hdr_dest = DEST_NONE;
    if (stat.regular) begin
      if (stat.name_flags[NF_DIR_A] || stat.name_flags[NF_DIR_B]) hdr_dest = DEST_DIR;
      else if (stat.name_flags[NF_FW]) hdr_dest = DEST_FW;
    end
  end

  always_comb begin
    phase_next        = phase;
    block_offset_next = block_offset;
    remaining_next    = remaining;
    cur_dest_next     = cur_dest;
    res_valid         = 1'b0;
    res.kind          = KIND_START;
    res.dest          = DEST_NONE;
    res.payload       = '0;
    res.length        = '0;
    res.last          = 1'b0;
    if (step) begin
      case (phase)
        PH_HEADER: begin
          block_offset_next = off_inc;
          if (block_offset == LAST_OFF) begin
            if (!stat.name_flags[NF_NAME]) begin
              res_valid  = 1'b1;
              res.kind   = KIND_END;
              phase_next = PH_HALT;
            end else if (!stat.magic_ok) begin
              res_valid  = 1'b1;
              res.kind   = KIND_CORRUPT;
              phase_next = PH_HALT;
            end else begin
              cur_dest_next  = hdr_dest;
              remaining_next = stat.size;
              if (hdr_dest != DEST_NONE) begin
                res_valid  = 1'b1;
                res.kind   = KIND_START;
                res.dest   = hdr_dest;
                res.length = stat.size;
              end
              phase_next = (stat.size != '0) ? PH_DATA : PH_HEADER;
            end
          end
        end
        PH_DATA: begin
          block_offset_next = off_inc;
          if (cur_dest != DEST_NONE) begin
            res_valid   = 1'b1;
            res.kind    = KIND_BYTE;
            res.dest    = cur_dest;
            res.payload = data_byte;
            res.last    = (remaining == SIZE_W'(1));
          end
          remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = (off_inc == '0) ? PH_HEADER : PH_PAD;
          end
        end
        PH_PAD: begin
          block_offset_next = off_inc;
          if (off_inc == '0) phase_next = PH_HEADER;
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      block_offset <= '0;
      remaining    <= '0;
      cur_dest     <= DEST_NONE;
    end else begin
      phase        <= phase_next;
      block_offset <= block_offset_next;
      remaining    <= remaining_next;
      cur_dest     <= cur_dest_next;
    end
  end

endmodule

FILE: rtl/core/tar_stream_router.sv
// ----------------------------------------------------------------------------
// tar_stream_router
// Byte-serial ustar archive walker that routes selected file payloads.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_ready | data_byte
//   out     | out_valid/out_ready | kind, destination, payload_byte,
//           |                     | file_length, last_of_file
//
// One archive word per clock sustained while the output is not stalled; a word
// waits in the input register until parsed, and its result (if any) is held in
// the output register. The rate is set by the single parse pass between them.
// rst (synchronous) returns the walker to the start of a header block.
// A stalled output holds the pipe; the input register still fills, and words
// that yield no result drain whenever the output slot is free.
// After an end-of-archive or corrupt result every word is swallowed.
//
`include "tar_stream_router_macros.svh"

module tar_stream_router (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  destination,
  output logic [7:0]  payload_byte,
  output logic [35:0] file_length,
  output logic        last_of_file
);
  import tsr_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_word;

  // output register
  result_t    out_res;

  logic              out_free;   // output slot empty or being drained
  logic              step;       // parse the buffered word this cycle
  logic              hdr_en;
  logic [OFF_W-1:0]  off;
  hdr_stat_t         stat;
  logic              res_valid;
  result_t           res;

  assign out_free = !out_valid || out_ready;
  assign step     = in_full && out_free;
  assign in_ready = !in_full || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word <= data_byte;
    end
  end

  // header field parser
  tsr_hdr u_hdr (
    .clk       (clk),
    .rst       (rst),
    .hdr_en    (hdr_en),
    .off       (off),
    .data_byte (in_word),
    .stat      (stat)
  );

  // phase / offset / payload count sequencer
  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_word),
    .stat      (stat),
    .hdr_en    (hdr_en),
    .off       (off),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign destination  = out_res.dest;
  assign payload_byte = out_res.payload;
  assign file_length  = out_res.length;
  assign last_of_file = out_res.last;

  // A payload word always belongs to a routed file.
  `TSR_ASSERT_NOW(a_byte_routed, clk, rst,
    out_valid && (kind == KIND_BYTE), destination != DEST_NONE,
    "payload word without destination")

  // Terminal results carry no destination and no length.
  `TSR_ASSERT_NOW(a_term_clean, clk, rst,
    out_valid && ((kind == KIND_END) || (kind == KIND_CORRUPT)),
    (destination == DEST_NONE) && (file_length == '0) && !last_of_file,
    "terminal result with stray fields")

  // Nothing follows a terminal result.
  `TSR_ASSERT_NEXT(a_halt_quiet, clk, rst,
    out_valid && out_ready && ((kind == KIND_END) || (kind == KIND_CORRUPT)),
    !out_valid,
    "result after end of archive")

endmodule
